/* design/mutation_selection_filter_core_defines.svh */
// Assertion macros for the mutation selection filter.
// Used by the port checker; expects i_clk and i_rst_n in the enclosing scope.
`ifndef MUTATION_SELECTION_FILTER_CORE_DEFINES_SVH
`define MUTATION_SELECTION_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define MSF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define MSF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/msf_pkg.sv */
// Shared types and constants of the mutation selection filter.
// No dependencies; used by the front end, back end, top level and the checker.
package msf_pkg;

    typedef enum logic [2:0] {
        VERDICT_IGNORED      = 3'd0,
        VERDICT_KEPT_SILENT  = 3'd1,
        VERDICT_KEPT_REPLACE = 3'd2,
        VERDICT_REVERT       = 3'd3,
        VERDICT_SKIPPED      = 3'd4
    } t_verdict;

    typedef enum logic [1:0] {
        ZONE_FWR    = 2'd0,
        ZONE_CDR    = 2'd1,
        ZONE_ANCHOR = 2'd2,
        ZONE_SKIP   = 2'd3
    } t_region;

    localparam int unsigned Q_BITS = 16;
    localparam logic [16:0] Q_ONE  = 17'h1_0000;

    localparam logic [2:0] CFG_STRENGTH   = 3'd0;
    localparam logic [2:0] CFG_CDR_BASE   = 3'd1;
    localparam logic [2:0] CFG_FWR_BASE   = 3'd2;
    localparam logic [2:0] CFG_ANCHOR_BASE = 3'd3;

    localparam logic [2:0] SEG_V           = 3'd0;
    localparam logic [2:0] SEG_J           = 3'd4;
    localparam logic [2:0] SEG_LAST_CODING = 3'd4;

    localparam logic [2:0] GERM_NONE = 3'd5;
    localparam logic [1:0] SLOT_NONE = 2'd3;

    localparam logic [15:0] V_EDGE_A = 16'd78;
    localparam logic [15:0] V_EDGE_B = 16'd114;
    localparam logic [15:0] V_EDGE_C = 16'd165;
    localparam logic [15:0] V_EDGE_D = 16'd195;
    localparam logic [16:0] J_ANCHOR_SPAN = 17'd3;

    localparam logic [7:0] AA_UNKNOWN = "?";

    // Standard genetic code, index {first, second, third} with T,C,A,G = 0..3.
    localparam logic [7:0] AMINO_OF [64] = '{
        "F","F","L","L","S","S","S","S","Y","Y","*","*","C","C","*","W",
        "L","L","L","L","P","P","P","P","H","H","Q","Q","R","R","R","R",
        "I","I","I","M","T","T","T","T","N","N","K","K","S","S","R","R",
        "V","V","V","V","A","A","A","A","D","D","E","E","G","G","G","G"
    };

    typedef struct packed {
        logic [16:0] strength;
        logic [16:0] cdr_base;
        logic [16:0] fwr_base;
        logic [16:0] anchor_base;
    } t_cfg;

    // Classified item passed from front to back.
    typedef struct packed {
        logic        done;      // verdict final, no acceptance test needed
        t_verdict    verdict;
        t_region     region;
        logic [15:0] rnd;
    } t_mid;

    typedef struct packed {
        t_verdict verdict;
        t_region  region;
    } t_result;

endpackage

/* design/msf_fifo.sv */
// Small synchronous FIFO with flop storage and a fill count.
// No package dependency.
module msf_fifo #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    output logic                       o_full,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == FULL_COUNT);
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule

/* design/msf_front.sv */
// Front end: silent/replacement test by codon translation and region class.
// Depends on msf_pkg.
module msf_front (
    input  logic [16:0]   i_strength,
    input  logic          i_is_mutated,
    input  logic [2:0]    i_segment_code,
    input  logic [15:0]   i_germline_position,
    input  logic [1:0]    i_codon_slot,
    input  logic [2:0]    i_base_first,
    input  logic [2:0]    i_base_second,
    input  logic [2:0]    i_base_third,
    input  logic [2:0]    i_germline_base,
    input  logic          i_anchor_mark,
    input  logic [15:0]   i_v_anchor_pos,
    input  logic [15:0]   i_j_anchor_pos,
    input  logic [15:0]   i_random_word,
    output msf_pkg::t_mid o_item
);

    function automatic logic [7:0] translate(input logic [2:0] a, input logic [2:0] b,
                                             input logic [2:0] c);
        logic [5:0] idx;
        idx = {a[1:0], b[1:0], c[1:0]};
        if (a[2] || b[2] || c[2]) begin
            return msf_pkg::AA_UNKNOWN;
        end
        return msf_pkg::AMINO_OF[idx];
    endfunction

    logic [2:0]       g_first, g_second, g_third;
    logic [7:0]       aa_now, aa_germ;
    logic             repl;
    msf_pkg::t_region region;

    // Codon with the germline base put in this nucleotide's slot.
    always_comb begin
        g_first  = i_base_first;
        g_second = i_base_second;
        g_third  = i_base_third;
        case (i_codon_slot)
            2'd0:    g_first  = i_germline_base;
            2'd1:    g_second = i_germline_base;
            2'd2:    g_third  = i_germline_base;
            default: ;
        endcase
    end

    assign aa_now  = translate(i_base_first, i_base_second, i_base_third);
    assign aa_germ = translate(g_first, g_second, g_third);
    assign repl    = (i_germline_base == msf_pkg::GERM_NONE)
                  || (i_codon_slot == msf_pkg::SLOT_NONE)
                  || (aa_now != aa_germ);

    always_comb begin
        if (i_anchor_mark) begin
            region = msf_pkg::ZONE_ANCHOR;
        end else if (i_segment_code == msf_pkg::SEG_V) begin
            if (i_v_anchor_pos == '0) begin
                region = msf_pkg::ZONE_SKIP;
            end else if (i_germline_position >= i_v_anchor_pos) begin
                region = msf_pkg::ZONE_CDR;
            end else if (i_germline_position < msf_pkg::V_EDGE_A) begin
                region = msf_pkg::ZONE_FWR;
            end else if (i_germline_position < msf_pkg::V_EDGE_B) begin
                region = msf_pkg::ZONE_CDR;
            end else if (i_germline_position < msf_pkg::V_EDGE_C) begin
                region = msf_pkg::ZONE_FWR;
            end else if (i_germline_position < msf_pkg::V_EDGE_D) begin
                region = msf_pkg::ZONE_CDR;
            end else begin
                region = msf_pkg::ZONE_FWR;
            end
        end else if (i_segment_code == msf_pkg::SEG_J) begin
            if (i_j_anchor_pos == '0) begin
                region = msf_pkg::ZONE_SKIP;
            end else if ({1'b0, i_germline_position}
                         < ({1'b0, i_j_anchor_pos} + msf_pkg::J_ANCHOR_SPAN)) begin
                region = msf_pkg::ZONE_CDR;
            end else begin
                region = msf_pkg::ZONE_FWR;
            end
        end else begin
            region = msf_pkg::ZONE_CDR;
        end
    end

    always_comb begin
        o_item.done    = 1'b1;
        o_item.verdict = msf_pkg::VERDICT_IGNORED;
        o_item.region  = msf_pkg::ZONE_FWR;
        o_item.rnd     = i_random_word;
        if (i_strength == '0 || !i_is_mutated
            || i_segment_code > msf_pkg::SEG_LAST_CODING) begin
            o_item.verdict = msf_pkg::VERDICT_IGNORED;
        end else if (!repl) begin
            o_item.verdict = msf_pkg::VERDICT_KEPT_SILENT;
        end else if (region == msf_pkg::ZONE_SKIP) begin
            o_item.verdict = msf_pkg::VERDICT_SKIPPED;
            o_item.region  = msf_pkg::ZONE_SKIP;
        end else begin
            o_item.done    = 1'b0;
            o_item.verdict = msf_pkg::VERDICT_REVERT;
            o_item.region  = region;
        end
    end

endmodule

/* design/msf_back.sv */
// Back end: acceptance product, random compare and the result queue.
// Depends on msf_pkg and msf_fifo.
module msf_back #(
    parameter int OUT_DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  msf_pkg::t_cfg     i_cfg,
    input  msf_pkg::t_mid     i_mid,
    input  logic              i_mid_valid,
    output logic              o_mid_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output msf_pkg::t_result  o_result
);

    localparam int CW = $clog2(OUT_DEPTH+1);
    localparam int RW = $bits(msf_pkg::t_result);

    function automatic logic [16:0] sat_one(input logic [16:0] v);
        return (v > msf_pkg::Q_ONE) ? msf_pkg::Q_ONE : v;
    endfunction

    logic [16:0]      base, s_sat, b_gap;
    logic [33:0]      prod;
    logic             take;
    logic [CW:0]      used;
    logic [CW-1:0]    out_count;
    logic             out_full;
    logic [RW-1:0]    out_data;

    logic             r_a_valid;
    msf_pkg::t_mid    r_a_item;
    logic [33:0]      r_a_prod;

    logic [17:0]      reduction, accept;
    msf_pkg::t_result res;

    // Entries in the result queue plus the one in flight must leave room.
    assign used      = {1'b0, out_count} + (CW+1)'(r_a_valid);
    assign take      = i_mid_valid && (used < (CW+1)'(OUT_DEPTH));
    assign o_mid_pop = take;

    always_comb begin
        case (i_mid.region)
            msf_pkg::ZONE_ANCHOR: base = i_cfg.anchor_base;
            msf_pkg::ZONE_CDR:    base = i_cfg.cdr_base;
            default:              base = i_cfg.fwr_base;
        endcase
    end

    assign s_sat = sat_one(i_cfg.strength);
    assign b_gap = msf_pkg::Q_ONE - sat_one(base);
    assign prod  = s_sat * b_gap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_a_item <= i_mid;
            r_a_prod <= prod;
        end
    end

    assign reduction = r_a_prod[33:msf_pkg::Q_BITS];
    assign accept    = {1'b0, msf_pkg::Q_ONE} - reduction;

    always_comb begin
        res.verdict = r_a_item.verdict;
        res.region  = r_a_item.region;
        if (!r_a_item.done) begin
            res.verdict = ({2'b00, r_a_item.rnd} < accept) ? msf_pkg::VERDICT_KEPT_REPLACE
                                                           : msf_pkg::VERDICT_REVERT;
        end
    end

    msf_fifo #(
        .DEPTH (OUT_DEPTH),
        .WIDTH (RW)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_a_valid),
        .i_data  (res),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_data  (out_data),
        .o_empty (o_empty),
        .o_count (out_count)
    );

    // Credit check above keeps the queue from overflowing; full only gates pushes.
    assign o_result = (out_full || !out_full) ? msf_pkg::t_result'(out_data)
                                              : msf_pkg::t_result'(out_data);

endmodule

/* design/mutation_selection_filter_core.sv */
// Top level of the mutation selection filter: config registers, front end,
// decoupling queue and back end. Depends on msf_pkg, msf_front, msf_fifo, msf_back.
//
// Usage:
//   Input channel is a queue write port: an item (one nucleotide with its codon
//   context, anchors and a random word) is taken at a clock edge with push high
//   and full low. Results leave through a queue read port: while empty is low
//   the oldest result sits on o_verdict / o_region_class, and it is taken at an
//   edge with pop high. Exactly one result per item, in input order.
//   Config writes use i_cfg_valid / o_cfg_ready (ready is always high); index
//   0 strength, 1 CDR, 2 FWR, 3 anchor base acceptance; other indexes are dropped.
//   Items pass the middle queue, a back-end register and the result queue. Throughput:
//   one item per cycle while the result queue has room, via the single 17x17 multiplier.
//   Reset (synchronous, active low) clears config registers and both queues.
//   When pop stays low, results pile up in the result queue, then the
//   middle queue fills and full rises; nothing is dropped.
module mutation_selection_filter_core #(
    parameter int MID_DEPTH = 4,
    parameter int OUT_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,
    // input queue port
    input  logic        push,
    output logic        full,
    input  logic        i_is_mutated,
    input  logic [2:0]  i_segment_code,
    input  logic [15:0] i_germline_position,
    input  logic [1:0]  i_codon_slot,
    input  logic [2:0]  i_base_first,
    input  logic [2:0]  i_base_second,
    input  logic [2:0]  i_base_third,
    input  logic [2:0]  i_germline_base,
    input  logic        i_anchor_mark,
    input  logic [15:0] i_v_anchor_pos,
    input  logic [15:0] i_j_anchor_pos,
    input  logic [15:0] i_random_word,
    // result queue port
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_verdict,
    output logic [1:0]  o_region_class
);

    localparam int MW = $bits(msf_pkg::t_mid);

    msf_pkg::t_cfg    r_cfg, n_cfg;
    msf_pkg::t_mid    front_item, mid_item;
    logic [MW-1:0]    mid_data;
    logic             mid_empty, mid_pop;
    logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
    msf_pkg::t_result result;

    // Config registers, writable any cycle; firmware only writes when idle, not enforced here.
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                msf_pkg::CFG_STRENGTH:    n_cfg.strength    = i_cfg_data;
                msf_pkg::CFG_CDR_BASE:    n_cfg.cdr_base    = i_cfg_data;
                msf_pkg::CFG_FWR_BASE:    n_cfg.fwr_base    = i_cfg_data;
                msf_pkg::CFG_ANCHOR_BASE: n_cfg.anchor_base = i_cfg_data;
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Front: pure classification of the incoming nucleotide.
    msf_front u_front (
        .i_strength          (r_cfg.strength),
        .i_is_mutated        (i_is_mutated),
        .i_segment_code      (i_segment_code),
        .i_germline_position (i_germline_position),
        .i_codon_slot        (i_codon_slot),
        .i_base_first        (i_base_first),
        .i_base_second       (i_base_second),
        .i_base_third        (i_base_third),
        .i_germline_base     (i_germline_base),
        .i_anchor_mark       (i_anchor_mark),
        .i_v_anchor_pos      (i_v_anchor_pos),
        .i_j_anchor_pos      (i_j_anchor_pos),
        .i_random_word       (i_random_word),
        .o_item              (front_item)
    );

    // Decoupling queue between classification and acceptance test.
    msf_fifo #(
        .DEPTH (MID_DEPTH),
        .WIDTH (MW)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_item),
        .o_full  (full),
        .i_pop   (mid_pop),
        .o_data  (mid_data),
        .o_empty (mid_empty),
        .o_count (mid_count)
    );

    assign mid_item = msf_pkg::t_mid'(mid_data);

    msf_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_mid       (mid_item),
        .i_mid_valid (!mid_empty && (mid_count != '0)),
        .o_mid_pop   (mid_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (result)
    );

    assign o_verdict      = result.verdict;
    assign o_region_class = result.region;

endmodule

/* design/msf_checker.sv */
// Port-level checker for the mutation selection filter, bound to the top level.
// Depends on msf_pkg and mutation_selection_filter_core_defines.svh.
`include "mutation_selection_filter_core_defines.svh"

module msf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [2:0] o_verdict,
    input logic [1:0] o_region_class
);

    logic [7:0] r_pending, n_pending;
    logic       push_acc, pop_acc;
    logic       res_stalled, plain_res, plain_fwr;
    logic [4:0] res_bus;

    assign push_acc = push && !full;
    assign pop_acc  = pop && !empty;

    assign res_stalled = !empty && !pop;
    assign res_bus     = {o_verdict, o_region_class};
    // Ignored and silent verdicts carry the FWR region code.
    assign plain_res   = !empty && (o_verdict == msf_pkg::VERDICT_IGNORED
                                    || o_verdict == msf_pkg::VERDICT_KEPT_SILENT);
    assign plain_fwr   = (o_region_class == msf_pkg::ZONE_FWR);

    // Items accepted but whose result has not been taken yet.
    always_comb begin
        n_pending = r_pending;
        if (push_acc && !pop_acc) begin
            n_pending = r_pending + 8'd1;
        end else if (pop_acc && !push_acc) begin
            n_pending = r_pending - 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    `MSF_ASSERT_NOW(a_no_invented, !empty, r_pending != 8'd0, "result with no item pending")

    `MSF_ASSERT_NOW(a_not_full_idle, r_pending == 8'd0, !full, "full while nothing pending")

    `MSF_ASSERT_NEXT(a_stall_holds, res_stalled, !empty && $stable(res_bus), "held result moved")

    `MSF_ASSERT_NOW(a_region_of_verdict, plain_res, plain_fwr, "region set on non-replacement")

endmodule

bind mutation_selection_filter_core msf_checker u_msf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .push           (push),
    .full           (full),
    .empty          (empty),
    .pop            (pop),
    .o_verdict      (o_verdict),
    .o_region_class (o_region_class)
);
